// ===== design/sas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sas_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package sas_pkg;
  localparam int unsigned MaxText   = 256;
  localparam int unsigned Alphabet  = 16;
  localparam int unsigned MaxStates = 512;
  localparam int unsigned SymW      = 4;

  localparam logic CmdAppend = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef enum logic [3:0] {
    OpNone,
    OpClrWr,
    OpStart,
    OpRdTr,
    OpRdLen,
    OpWrFresh,
    OpWalkWr,
    OpRdNxtLen,
    OpCopyRd,
    OpCopyWr,
    OpCloneFin,
    OpRedirWr,
    OpLinkSelf,
    OpQryRd,
    OpQryUse,
    OpLinkNxt
  } op_e;

  typedef struct packed {
    op_e  op;
    logic qry_last;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic tr_zero;
    logic tr_is_nxt;
    logic cur_root_end;
    logic len_match;
    logic copy_done;
    logic full;
    logic sym_bad;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== design/sas_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sas_datapath
// automaton memories, walk registers and query cursor
// ----------------------------------------------------------------------------
module sas_datapath #(
  parameter int unsigned MAX_TEXT   = sas_pkg::MaxText,
  parameter int unsigned ALPHABET   = sas_pkg::Alphabet,
  parameter int unsigned MAX_STATES = sas_pkg::MaxStates
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  sas_pkg::dp_cmd_t          cmd_i,
  input  wire  [sas_pkg::SymW-1:0]  symbol_i,
  input  wire                       first_i,
  output sas_pkg::dp_sts_t          sts_o,
  output logic                      alive_o
);
  import sas_pkg::*;

  localparam int unsigned SW = $clog2(MAX_STATES);
  localparam int unsigned AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned TW = SW + AW;
  localparam int unsigned LW = $clog2(MAX_TEXT + 1);
  localparam int unsigned CW = $clog2(MAX_STATES + 1);
  localparam int unsigned TDEPTH = MAX_STATES * (1 << AW);

  logic [SW-1:0] tr_mem  [TDEPTH];
  logic [LW-1:0] len_mem [MAX_STATES];
  logic [SW-1:0] lnk_mem [MAX_STATES];

  logic [SW-1:0] cur_q, fresh_q, nxt_q, clone_q, last_q, qcur_q, lnk_rd_q, tr_rd_q;
  logic [LW-1:0] len_rd_q, want_q, text_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] sym_q, ci_q;
  logic [TW:0]   clr_q;
  logic          rootnone_q, alive_q, have_q;

  logic [AW-1:0] sym_w;
  logic          sym_bad;
  assign sym_w   = AW'(symbol_i);
  assign sym_bad = (32'(symbol_i) >= ALPHABET);

  // single table port: address and write per op
  logic          tr_we;
  logic [TW-1:0] tr_addr;
  logic [SW-1:0] tr_wd;
  always_comb begin
    tr_we = 1'b0;
    tr_wd = '0;
    tr_addr = {cur_q, sym_q};
    case (cmd_i.op)
      OpClrWr:   begin tr_we = 1'b1; tr_addr = clr_q[TW-1:0]; end
      OpWalkWr:  begin tr_we = 1'b1; tr_wd = fresh_q; end
      OpRedirWr: begin tr_we = 1'b1; tr_wd = clone_q; end
      OpCopyRd:  tr_addr = {nxt_q, ci_q};
      OpCopyWr:  begin tr_we = 1'b1; tr_addr = {clone_q, ci_q}; tr_wd = tr_rd_q; end
      OpQryRd:   tr_addr = {(first_i ? SW'(0) : qcur_q), sym_w};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tr_we) tr_mem[tr_addr] <= tr_wd;
    tr_rd_q <= tr_mem[tr_addr];
  end

  // state length / link port, address chosen by op
  logic [SW-1:0] sl_addr;
  logic          len_we, lnk_we;
  logic [LW-1:0] len_wd;
  logic [SW-1:0] lnk_wd;
  always_comb begin
    sl_addr = cur_q;
    len_we = 1'b0; lnk_we = 1'b0; len_wd = '0; lnk_wd = '0;
    case (cmd_i.op)
      // root length is zero
      OpClrWr:    begin sl_addr = '0; len_we = 1'b1; end
      OpStart:    sl_addr = last_q;
      OpWrFresh:  begin sl_addr = fresh_q; len_we = 1'b1; len_wd = len_rd_q + 1'b1; end
      OpRdNxtLen: sl_addr = tr_rd_q;
      // keep the link of nxt on the read port during the copy
      OpCopyRd, OpCopyWr: sl_addr = nxt_q;
      OpCloneFin: begin sl_addr = clone_q; len_we = 1'b1; len_wd = want_q;
                        lnk_we = 1'b1; lnk_wd = lnk_rd_q; end
      OpLinkNxt:  begin sl_addr = nxt_q; lnk_we = 1'b1; lnk_wd = clone_q; end
      OpLinkSelf: begin sl_addr = fresh_q; lnk_we = 1'b1; lnk_wd = have_q ? nxt_q : '0; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[sl_addr] <= len_wd;
    if (lnk_we) lnk_mem[sl_addr] <= lnk_wd;
    len_rd_q <= len_mem[sl_addr];
    lnk_rd_q <= lnk_mem[sl_addr];
  end

  // extra link write ports avoided: nxt link and fresh link done in sequence
  logic [SW-1:0] link_after;
  assign link_after = lnk_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; cnt_q <= CW'(1); last_q <= '0; text_q <= '0; rootnone_q <= 1'b1;
      qcur_q <= '0; alive_q <= 1'b1; cur_q <= '0; fresh_q <= '0; nxt_q <= '0;
      clone_q <= '0; want_q <= '0; sym_q <= '0; ci_q <= '0; have_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OpClrWr: clr_q <= clr_q + 1'b1;
        OpStart: begin
          sym_q <= sym_w; cur_q <= last_q; fresh_q <= cnt_q[SW-1:0];
          last_q <= cnt_q[SW-1:0]; cnt_q <= cnt_q + 1'b1; text_q <= text_q + 1'b1;
          have_q <= 1'b1;
        end
        OpWalkWr: begin
          if (cur_q == '0 && rootnone_q) have_q <= 1'b0;
          else cur_q <= link_after;
        end
        // at the root the rewritten entry ends the redirect loop
        OpRedirWr: begin
          if (!(cur_q == '0 && rootnone_q)) cur_q <= link_after;
        end
        OpRdLen: begin
          nxt_q <= tr_rd_q; want_q <= len_rd_q + 1'b1;
        end
        OpCopyRd: ;
        OpRdNxtLen: begin
          clone_q <= cnt_q[SW-1:0]; ci_q <= '0;
        end
        OpCopyWr: ci_q <= ci_q + 1'b1;
        OpCloneFin: begin
          cnt_q <= cnt_q + 1'b1;
        end
        // fresh links to the clone from here on
        OpLinkNxt: nxt_q <= clone_q;
        OpLinkSelf: ;
        OpQryRd: begin
          if (first_i) qcur_q <= '0;
          alive_q <= (first_i || alive_q) && !sym_bad;
        end
        OpQryUse: begin
          // query answer resets the walk
          if (cmd_i.qry_last) begin
            qcur_q <= '0; alive_q <= 1'b1;
          end else if (tr_rd_q == '0) begin
            alive_q <= 1'b0;
          end else if (alive_q) begin
            qcur_q <= tr_rd_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.clr_done     = clr_q[TW];
  assign sts_o.tr_zero      = (tr_rd_q == '0);
  assign sts_o.tr_is_nxt    = (tr_rd_q == nxt_q);
  assign sts_o.cur_root_end = !have_q;
  assign sts_o.len_match    = (len_rd_q == want_q);
  assign sts_o.copy_done    = (32'(ci_q) == ALPHABET - 1);
  assign sts_o.full         = (32'(text_q) >= MAX_TEXT) || (32'(cnt_q) + 2 > MAX_STATES);
  assign sts_o.sym_bad      = sym_bad;
  assign alive_o            = alive_q;
endmodule
`default_nettype wire

// ===== design/sas_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sas_ctrl
// sequencer for table clear, append walks, clone and queries
// ----------------------------------------------------------------------------
module sas_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               command_i,
  input  wire               last_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic              kind_o,
  output logic              found_o,
  output logic              full_error_o,
  input  wire               alive_i,
  input  sas_pkg::dp_sts_t  sts_i,
  output sas_pkg::dp_cmd_t  cmd_o
);
  import sas_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StRdLen, StWalkRd, StWalkChk, StLinkRd, StLenRd,
    StLenChk, StCopyRd, StCopyWr, StClFin, StRedRd, StRedChk, StLink,
    StQry
  } state_e;

  state_e state_q;
  logic   qlast_q;

  // a word is taken only when the result register is free by the next cycle
  assign in_ready_o = (state_q == StIdle) && (!out_valid_o || out_ready_i);

  always_comb begin
    cmd_o.op = OpNone;
    cmd_o.qry_last = 1'b0;
    case (state_q)
      StClear:   cmd_o.op = sts_i.clr_done ? OpNone : OpClrWr;
      StIdle:    if (in_valid_i && in_ready_o) begin
                   if (command_i == CmdQuery) cmd_o.op = OpQryRd;
                   else if (!sts_i.full && !sts_i.sym_bad) cmd_o.op = OpStart;
                 end
      StRdLen:   cmd_o.op = OpWrFresh;
      StWalkChk: cmd_o.op = sts_i.tr_zero ? OpWalkWr : OpRdLen;
      StLenRd:   cmd_o.op = OpRdNxtLen;
      StLenChk:  cmd_o.op = sts_i.len_match ? OpLinkSelf : OpNone;
      StCopyRd:  cmd_o.op = OpCopyRd;
      StCopyWr:  cmd_o.op = OpCopyWr;
      StClFin:   cmd_o.op = OpCloneFin;
      StRedChk:  cmd_o.op = sts_i.tr_is_nxt ? OpRedirWr : OpLinkNxt;
      StLink:    cmd_o.op = OpLinkSelf;
      StQry: begin
        cmd_o.op = OpQryUse;
        cmd_o.qry_last = qlast_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; out_valid_o <= 1'b0; kind_o <= 1'b0; found_o <= 1'b0;
      full_error_o <= 1'b0; qlast_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StClear: if (sts_i.clr_done) state_q <= StIdle;
        StIdle: if (in_valid_i && in_ready_o) begin
          if (command_i == CmdQuery) begin
            qlast_q <= last_i; state_q <= StQry;
          end else begin
            out_valid_o <= 1'b1; kind_o <= CmdAppend; found_o <= 1'b0;
            full_error_o <= sts_i.full;
            if (!sts_i.full && !sts_i.sym_bad) state_q <= StRdLen;
          end
        end
        StRdLen:   state_q <= StWalkRd;
        StWalkRd:  state_q <= StWalkChk;
        StWalkChk: state_q <= sts_i.tr_zero ? StLinkRd : StLenRd;
        StLinkRd:  state_q <= sts_i.cur_root_end ? StLink : StWalkRd;
        StLenRd:   state_q <= StLenChk;
        StLenChk:  state_q <= sts_i.len_match ? StIdle : StCopyRd;
        StCopyRd:  state_q <= StCopyWr;
        StCopyWr:  state_q <= sts_i.copy_done ? StClFin : StCopyRd;
        StClFin:   state_q <= StRedRd;
        StRedRd:   state_q <= StRedChk;
        StRedChk:  state_q <= sts_i.tr_is_nxt ? StRedRd : StLink;
        StLink:    state_q <= StIdle;
        StQry: begin
          state_q <= StIdle;
          // result register is free here since the word was taken
          if (qlast_q) begin
            out_valid_o <= 1'b1; kind_o <= CmdQuery;
            found_o <= alive_i && !sts_i.tr_zero; full_error_o <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/suffix_automaton_substring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// suffix_automaton_substring
// online suffix automaton with symbol-serial substring queries
// ----------------------------------------------------------------------------
// After reset the transition table is swept clear, one entry a cycle
// (MAX_STATES * 2**clog2(ALPHABET) entries, 8192 by default), before any
// word is taken. An append walks the suffix links from the last state and
// writes each missing transition to the fresh state; a clone copies the
// transitions one alphabet symbol at a time, then redirects transitions to
// it. The clone cost is set by the single-port transition memory. A query
// symbol is a table read and then a use step. A word is taken only when the
// result register frees, so a stalled receiver stalls the input.
module suffix_automaton_substring #(
  parameter int unsigned MAX_TEXT   = sas_pkg::MaxText,
  parameter int unsigned ALPHABET   = sas_pkg::Alphabet,
  parameter int unsigned MAX_STATES = sas_pkg::MaxStates
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire                       command_i,
  input  wire  [sas_pkg::SymW-1:0]  symbol_i,
  input  wire                       first_i,
  input  wire                       last_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic                      kind_o,
  output logic                      found_o,
  output logic                      full_error_o
);
  import sas_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    alive;

  sas_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .last_i,
    .out_valid_o, .out_ready_i, .kind_o, .found_o, .full_error_o,
    .alive_i(alive), .sts_i(sts), .cmd_o(cmd)
  );

  sas_datapath #(
    .MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET), .MAX_STATES(MAX_STATES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .symbol_i, .first_i, .sts_o(sts), .alive_o(alive)
  );

`ifndef SYNTHESIS
  a_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !found_o) else $error("append word shows found");
  a_qry_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !full_error_o) else $error("query word shows full");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_suffix_automaton_substring.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_suffix_automaton_substring
// self-checking testbench for the suffix automaton substring block
// ----------------------------------------------------------------------------
// A directed table covers the corner cases first. Random appends and
// substring queries follow. Each accepted word is run through a local copy
// of the automaton. Every result is checked in order against the expected
// answer. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_suffix_automaton_substring;
  import sas_pkg::*;

  typedef struct packed {
    logic kind;
    logic found;
    logic full_error;
  } answer_t;

  typedef struct {
    logic    cmd;
    int      sym;
    logic    first;
    logic    last;
    bit      typed;
    answer_t ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic command_i = 1'b0;
  logic [SymW-1:0] symbol_i = '0;
  logic first_i = 1'b0;
  logic last_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, kind_o, found_o, full_error_o;

  suffix_automaton_substring dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .symbol_i,
    .first_i, .last_i, .out_valid_o, .out_ready_i, .kind_o, .found_o,
    .full_error_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // local copy of the automaton
  int  len_mem [MaxStates];
  int  link_mem [MaxStates];
  int  next_mem [MaxStates*Alphabet];
  bit  root_no_link;
  int  tail_state, n_states, text_len, walk_state;
  bit  walk_alive;
  int  text_syms [$];

  answer_t answer_q [$];
  int errors = 0;
  int n_results = 0;
  int n_full = 0;
  int n_found = 0;
  int idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  bit hold_req = 1'b0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit step_link(ref int st);
    if (st == 0 && root_no_link) return 1'b0;
    st = link_mem[st];
    return 1'b1;
  endfunction

  function automatic void extend_text(int sym);
    int fresh, cur, nxt, want, clone;
    bit have;
    fresh = n_states;
    cur = tail_state;
    have = 1'b1;
    n_states++;
    len_mem[fresh] = len_mem[cur] + 1;
    tail_state = fresh;
    while (have && next_mem[cur*Alphabet+sym] == 0) begin
      next_mem[cur*Alphabet+sym] = fresh;
      have = step_link(cur);
    end
    if (!have) begin
      link_mem[fresh] = 0;
      return;
    end
    nxt = next_mem[cur*Alphabet+sym];
    want = len_mem[cur] + 1;
    if (len_mem[nxt] == want) begin
      link_mem[fresh] = nxt;
      return;
    end
    clone = n_states;
    n_states++;
    for (int a = 0; a < Alphabet; a++) next_mem[clone*Alphabet+a] = next_mem[nxt*Alphabet+a];
    link_mem[clone] = link_mem[nxt];
    len_mem[clone] = want;
    while (have && next_mem[cur*Alphabet+sym] == nxt) begin
      next_mem[cur*Alphabet+sym] = clone;
      have = step_link(cur);
    end
    link_mem[nxt] = clone;
    link_mem[fresh] = clone;
  endfunction

  // returns 1 when the word produces a result
  function automatic bit predict_answer(logic cmd, int sym, logic first, logic last,
                                        output answer_t ans);
    int t;
    ans = '0;
    if (cmd == CmdAppend) begin
      if (text_len >= MaxText || n_states + 2 > MaxStates) begin
        ans.full_error = 1'b1;
        return 1'b1;
      end
      if (sym >= Alphabet) return 1'b1;
      extend_text(sym);
      text_syms.push_back(sym);
      text_len++;
      return 1'b1;
    end
    if (first) begin
      walk_state = 0;
      walk_alive = 1'b1;
    end
    if (walk_alive) begin
      t = next_mem[walk_state*Alphabet+sym];
      if (t == 0) walk_alive = 1'b0;
      else walk_state = t;
    end
    if (!last) return 1'b0;
    ans.kind = 1'b1;
    ans.found = walk_alive;
    walk_state = 0;
    walk_alive = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_word(logic cmd, int sym, logic first, logic last,
                           bit typed = 1'b0, answer_t typed_ans = '0);
    int gap;
    answer_t ans;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 46) || (idle_mode == 3 && $urandom_range(99) < 16))
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    symbol_i <= sym[SymW-1:0];
    first_i <= first;
    last_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_answer(cmd, sym, first, last, ans))
      answer_q.push_back(typed ? typed_ans : ans);
  endtask

  // result side: checks and stalls
  initial begin : receiver
    answer_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (answer_q.size() == 0) begin
          report("unexpected word", int'(kind_o), -1);
        end else begin
          want = answer_q.pop_front();
          if (kind_o !== want.kind) report("kind", int'(kind_o), int'(want.kind));
          if (found_o !== want.found) report("found", int'(found_o), int'(want.found));
          if (full_error_o !== want.full_error)
            report("full_error", int'(full_error_o), int'(want.full_error));
          n_full += int'(want.full_error);
          n_found += int'(want.found);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (idle_mode == 2) begin
        out_ready_i <= ($urandom_range(99) >= 46);
      end else if (idle_mode == 3) begin
        out_ready_i <= ($urandom_range(99) >= 16);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("tb_suffix_automaton_substring failed");
    $finish;
  end

  task automatic random_word();
    int plen, start, pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // small alphabet most of the time so that clones appear
      send_word(CmdAppend, ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (pick < 85 && text_syms.size() > 0) begin
      plen = $urandom_range(1, (text_syms.size() < 6) ? text_syms.size() : 6);
      start = $urandom_range(text_syms.size() - plen);
      for (int k = 0; k < plen; k++) begin
        // occasionally corrupt a symbol of an otherwise real substring
        send_word(CmdQuery,
                  ($urandom_range(9) == 0) ? $urandom_range(15) : text_syms[start+k],
                  (k == 0), (k == plen - 1));
      end
    end else begin
      send_word(CmdQuery, $urandom_range(15), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    row_t rows [$];
    int waited;
    for (int i = 0; i < MaxStates; i++) begin
      len_mem[i] = 0;
      link_mem[i] = 0;
    end
    foreach (next_mem[i]) next_mem[i] = 0;
    root_no_link = 1'b1;
    tail_state = 0;
    n_states = 1;
    text_len = 0;
    walk_state = 0;
    walk_alive = 1'b1;

    //        cmd        sym  first last typed {kind found full}
    rows = '{
      '{CmdQuery,  0,  1, 1, 1, 3'b100},  // empty text
      '{CmdQuery,  15, 0, 1, 1, 3'b100},
      '{CmdAppend, 0,  1, 1, 1, 3'b000},
      '{CmdAppend, 15, 0, 0, 1, 3'b000},
      '{CmdAppend, 0,  0, 1, 1, 3'b000},
      '{CmdAppend, 15, 1, 0, 1, 3'b000},
      '{CmdAppend, 0,  0, 0, 1, 3'b000},
      '{CmdQuery,  15, 1, 1, 1, 3'b110},
      '{CmdQuery,  0,  1, 0, 0, 3'b000},
      '{CmdQuery,  15, 0, 0, 0, 3'b000},
      '{CmdQuery,  0,  0, 1, 0, 3'b000},
      '{CmdQuery,  15, 0, 1, 0, 3'b000},  // fresh walk without first mark
      '{CmdQuery,  0,  1, 0, 0, 3'b000},
      '{CmdQuery,  0,  0, 1, 0, 3'b000},
      '{CmdQuery,  15, 1, 0, 0, 3'b000},
      '{CmdAppend, 15, 0, 0, 0, 3'b000},  // append inside a pattern
      '{CmdQuery,  15, 0, 1, 0, 3'b000},
      '{CmdQuery,  7,  1, 0, 0, 3'b000},
      '{CmdQuery,  0,  1, 1, 0, 3'b000},  // first mark restarts the walk
      '{CmdAppend, 1,  0, 0, 0, 3'b000},
      '{CmdAppend, 1,  0, 0, 0, 3'b000},
      '{CmdQuery,  1,  1, 0, 0, 3'b000},
      '{CmdQuery,  1,  0, 1, 0, 3'b000}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].sym, rows[i].first, rows[i].last,
                rows[i].typed, rows[i].ans);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      if (ph == 2) begin
        // long receiver hold-off while words keep coming
        hold_req = 1'b1;
        repeat (40) random_word();
        // then let the results drain before going on
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (answer_q.size() != 0) @(posedge clk_i);
      end
      repeat (165) random_word();
    end

    in_valid_i <= 1'b0;
    idle_mode = 0;
    waited = 0;
    while (answer_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (1000) @(posedge clk_i);
    if (answer_q.size() != 0) report("results left over", answer_q.size(), 0);

    $display("covered %0d results, %0d refused appends, %0d found patterns, text length %0d",
             n_results, n_full, n_found, text_len);
    $display("automaton ended with %0d states", n_states);
    if (errors == 0) begin
      $display("tb_suffix_automaton_substring passed");
    end else begin
      $display("tb_suffix_automaton_substring failed");
    end
    $finish;
  end
endmodule
